[hdl/charged_particle_implicit_push_unit_defines.svh]
// Assertion macros for the charged particle push unit.
// Used by the top level; every macro samples on clk_i and is disabled in reset.
`ifndef CHARGED_PARTICLE_IMPLICIT_PUSH_UNIT_DEFINES_SVH
`define CHARGED_PARTICLE_IMPLICIT_PUSH_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define CPPU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("cppu assertion failed");
`define CPPU_NEVER(lbl, cond) \
  `CPPU_ASSERT(lbl, !(cond))
`else
`define CPPU_ASSERT(lbl, prop)
`define CPPU_NEVER(lbl, cond)
`endif
`endif

[hdl/cppu_pkg.sv]
// Shared types and constants of the charged particle push unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package cppu_pkg;

  localparam int POS_W        = 48;
  localparam int COEF_W       = 32;
  localparam int BOX_W        = 47;
  localparam int SUB_W        = 7;
  localparam int MAX_SUBSTEPS = 64;
  localparam logic [BOX_W-1:0] BOX_RESET = 47'd21990232556;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_EX  = 3'd0,
    REG_EY  = 3'd1,
    REG_EZ  = 3'd2,
    REG_BX  = 3'd3,
    REG_BY  = 3'd4,
    REG_BZ  = 3'd5,
    REG_BOX = 3'd6
  } cfg_reg_e;

  // rounding bias preloaded into the accumulator on the first partial
  typedef enum logic [1:0] {
    BIAS_NONE  = 2'd0,
    BIAS_ROT   = 2'd1,
    BIAS_CROSS = 2'd2,
    BIAS_ACCEL = 2'd3
  } bias_e;

  typedef struct packed {
    logic signed [POS_W-1:0]  prev_x;
    logic signed [POS_W-1:0]  prev_y;
    logic signed [POS_W-1:0]  prev_z;
    logic signed [POS_W-1:0]  cur_x;
    logic signed [POS_W-1:0]  cur_y;
    logic signed [POS_W-1:0]  cur_z;
    logic signed [COEF_W-1:0] rot_coeff;
    logic signed [COEF_W-1:0] accel_coeff;
    logic [SUB_W-1:0]         substeps;
  } item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] new_prev_x;
    logic signed [POS_W-1:0] new_prev_y;
    logic signed [POS_W-1:0] new_prev_z;
    logic signed [POS_W-1:0] new_cur_x;
    logic signed [POS_W-1:0] new_cur_y;
    logic signed [POS_W-1:0] new_cur_z;
    logic                    was_clamped;
  } result_t;

  // one partial product request to the shared multiply-accumulate unit
  typedef struct packed {
    logic        issue;
    logic        first;
    logic        sub;
    logic [1:0]  part;
    bias_e       bias;
    logic [63:0] a;
    logic [63:0] b;
  } mac_op_t;

endpackage

`default_nettype wire

[hdl/cppu_mac.sv]
// Shared 64x64 multiply-accumulate unit built on one 33x33 signed multiplier.
// A product takes four partials; three-stage pipeline. Depends on cppu_pkg.
`default_nettype none

module cppu_mac import cppu_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mac_op_t              op_i,
  output logic signed [127:0]  acc_o
);

  logic               s1_vld_q, s1_first_q, s1_sub_q;
  bias_e              s1_bias_q;
  logic [1:0]         s1_shift_q;
  logic signed [32:0] s1_a_q, s1_b_q;
  logic               s2_vld_q, s2_first_q, s2_sub_q;
  bias_e              s2_bias_q;
  logic [1:0]         s2_shift_q;
  logic signed [65:0] s2_prod_q;
  logic signed [127:0] acc_q;
  logic signed [32:0] a_half, b_half;
  logic signed [127:0] prod_ext, prod_sh, base;

  // half selection: part[1] picks the upper word of a, part[0] of b
  assign a_half = op_i.part[1] ? {op_i.a[63], op_i.a[63:32]} : {1'b0, op_i.a[31:0]};
  assign b_half = op_i.part[0] ? {op_i.b[63], op_i.b[63:32]} : {1'b0, op_i.b[31:0]};

  // pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= op_i.issue;
      s2_vld_q <= s1_vld_q;
    end
  end

  // operand and product registers
  always_ff @(posedge clk_i) begin
    s1_a_q     <= a_half;
    s1_b_q     <= b_half;
    s1_first_q <= op_i.first;
    s1_sub_q   <= op_i.sub;
    s1_bias_q  <= op_i.bias;
    s1_shift_q <= 2'({1'b0, op_i.part[1]} + {1'b0, op_i.part[0]});
    s2_prod_q  <= s1_a_q * s1_b_q;
    s2_first_q <= s1_first_q;
    s2_sub_q   <= s1_sub_q;
    s2_bias_q  <= s1_bias_q;
    s2_shift_q <= s1_shift_q;
  end

  // align partial and pick the accumulation base
  always_comb begin
    prod_ext = {{62{s2_prod_q[65]}}, s2_prod_q};
    unique case (s2_shift_q)
      2'd0:    prod_sh = prod_ext;
      2'd1:    prod_sh = prod_ext <<< 32;
      2'd2:    prod_sh = prod_ext <<< 64;
      default: prod_sh = prod_ext <<< 96;
    endcase
    if (s2_first_q) begin
      unique case (s2_bias_q)
        BIAS_ROT:   base = 128'sd1 <<< 15;
        BIAS_CROSS: base = 128'sd1 <<< 23;
        BIAS_ACCEL: base = 128'sd1 <<< 31;
        default:    base = '0;
      endcase
    end else begin
      base = acc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_vld_q) begin
      acc_q <= s2_sub_q ? base - prod_sh : base + prod_sh;
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

[hdl/cppu_div.sv]
// Serial restoring divider: signed 128-bit numerator over a positive 64-bit
// denominator, rounded half away from zero, one quotient bit per cycle.
`default_nettype none

module cppu_div import cppu_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [127:0] num_i,
  input  logic [63:0]         den_i,
  output logic                done_o,
  output logic [63:0]         quot_o
);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_e;

  dstate_e      state_q;
  logic [6:0]   cnt_q;
  logic         neg_q;
  logic [127:0] num_q;
  logic [63:0]  rem_q, q_q, quot_q;
  logic         done_q;
  logic [127:0] mag_half;
  logic [64:0]  trial, diff;
  logic         ge;

  // |num| + den/2 in one adder: conditional invert with carry in
  assign mag_half = (num_i ^ {128{num_i[127]}}) + {65'd0, den_i[63:1]}
                  + {127'd0, num_i[127]};

  // one restoring step
  assign trial = {rem_q, num_q[127]};
  assign diff  = trial - {1'b0, den_i};
  assign ge    = !diff[64];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        D_IDLE: if (start_i) begin
          state_q <= D_RUN;
          cnt_q   <= '0;
        end
        D_RUN: begin
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'd127) state_q <= D_FIN;
        end
        D_FIN: begin
          done_q  <= 1'b1;
          state_q <= D_IDLE;
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == D_IDLE && start_i) begin
      neg_q <= num_i[127];
      num_q <= mag_half;
      rem_q <= '0;
      q_q   <= '0;
    end else if (state_q == D_RUN) begin
      rem_q <= ge ? diff[63:0] : trial[63:0];
      q_q   <= {q_q[62:0], ge};
      num_q <= {num_q[126:0], 1'b0};
    end else if (state_q == D_FIN) begin
      quot_q <= neg_q ? 64'd0 - q_q : q_q;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

[hdl/charged_particle_implicit_push_unit.sv]
// Top level of the charged particle push unit: config registers, sequencer,
// shared multiply-accumulate unit and serial divider. Depends on cppu_pkg.
//
//   channel  | signals                                  | handshake
//   ---------+------------------------------------------+---------------------------
//   item     | start, busy, item_i                      | taken when start & !busy
//   result   | result_valid_o, result_o                 | one-cycle strobe, no stall
//   config   | cfg_we_i, cfg_idx_i, cfg_wdata_i         | written when cfg_we_i high
//
// Setup (coefficients and the rotation matrix) takes 12 products. Each substep
// runs three cross products, then per coordinate a row product and the 128-step
// serial divider. Substeps are capped at 64.
// Zero substeps returns the input on the next cycle.
// busy is high for the whole item; the result strobe comes with busy low.
// The receiver cannot stall; reset clears control and loads register resets.
`default_nettype none
`include "charged_particle_implicit_push_unit_defines.svh"

module charged_particle_implicit_push_unit import cppu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  item_t             item_i,
  output logic              result_valid_o,
  output result_t           result_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [BOX_W-1:0]  cfg_wdata_i
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SETUP, ST_PP, ST_CROSS, ST_MAT, ST_DIV, ST_DONE
  } state_e;

  state_e                   state_q;
  logic [3:0]               pc_q;
  logic [2:0]               job_q;
  logic [SUB_W-1:0]         step_q;
  logic                     valid_q, clamp_q;
  logic signed [COEF_W-1:0] e_q [3];
  logic signed [COEF_W-1:0] b_q [3];
  logic [BOX_W-1:0]         box_q;
  logic signed [COEF_W-1:0] rot_q, accel_q;
  logic signed [POS_W-1:0]  x0_q [3];
  logic signed [POS_W-1:0]  x1_q [3];
  logic signed [COEF_W-1:0] p_q [3];
  logic signed [COEF_W-1:0] ac_q [3];
  logic signed [63:0]       m_q [3][3];
  logic signed [63:0]       d_q [3];
  logic [63:0]              den_q;
  result_t                  res_q;

  mac_op_t             mac_op;
  logic signed [127:0] acc;
  logic                div_done;
  logic [63:0]         div_quot;
  logic                accept, consume;
  logic [1:0]          nterms, term, ji, jn, jp;
  logic [3:0]          issue_n;
  logic [2:0]          jm3;
  logic [SUB_W-1:0]    n_eff;
  logic signed [47:0]  p_raw;
  logic signed [COEF_W-1:0] p_sat;
  logic signed [63:0]  pp, d_new, v, v_clamped, h64, p24_0, p24_1, p24_2;
  logic                clamp_hit;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign n_eff  = (item_i.substeps > SUB_W'(MAX_SUBSTEPS)) ? SUB_W'(MAX_SUBSTEPS)
                                                          : item_i.substeps;
  assign ji  = job_q[1:0];
  assign jn  = (ji == 2'd2) ? 2'd0 : ji + 2'd1;
  assign jp  = (ji == 2'd0) ? 2'd2 : ji - 2'd1;
  assign jm3 = job_q - 3'd3;

  // terms per product job in each phase
  always_comb begin
    unique case (state_q)
      ST_CROSS: nterms = 2'd2;
      ST_MAT:   nterms = 2'd3;
      default:  nterms = 2'd1;
    endcase
  end
  assign issue_n = {nterms, 2'b00};
  assign term    = pc_q[3:2];
  assign consume = (state_q == ST_SETUP || state_q == ST_PP || state_q == ST_CROSS
                    || state_q == ST_MAT) && (pc_q == issue_n + 4'd2);

  // operand selection for the shared multiplier
  always_comb begin
    mac_op       = '0;
    mac_op.part  = pc_q[1:0];
    mac_op.first = (pc_q == 4'd0);
    mac_op.issue = (pc_q < issue_n) && (state_q == ST_SETUP || state_q == ST_PP
                   || state_q == ST_CROSS || state_q == ST_MAT);
    unique case (state_q)
      ST_SETUP: begin
        if (job_q < 3'd3) begin
          mac_op.a    = 64'(rot_q);
          mac_op.b    = 64'(b_q[ji]);
          mac_op.bias = BIAS_ROT;
        end else begin
          mac_op.a    = 64'(accel_q);
          mac_op.b    = 64'(e_q[jm3[1:0]]);
          mac_op.bias = BIAS_ACCEL;
        end
      end
      ST_PP: begin
        unique case (job_q)
          3'd3:    begin mac_op.a = 64'(p_q[0]); mac_op.b = 64'(p_q[1]); end
          3'd4:    begin mac_op.a = 64'(p_q[0]); mac_op.b = 64'(p_q[2]); end
          3'd5:    begin mac_op.a = 64'(p_q[1]); mac_op.b = 64'(p_q[2]); end
          default: begin mac_op.a = 64'(p_q[ji]); mac_op.b = 64'(p_q[ji]); end
        endcase
      end
      ST_CROSS: begin
        mac_op.bias = BIAS_CROSS;
        if (term == 2'd0) begin
          mac_op.a = 64'(p_q[jn]);
          mac_op.b = 64'(x0_q[jp]);
        end else begin
          mac_op.a   = 64'(p_q[jp]);
          mac_op.b   = 64'(x0_q[jn]);
          mac_op.sub = 1'b1;
        end
      end
      ST_MAT: begin
        mac_op.a = m_q[ji][term];
        mac_op.b = d_q[term];
      end
      default: ;
    endcase
  end

  cppu_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (mac_op),
    .acc_o  (acc)
  );

  cppu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (consume && state_q == ST_MAT),
    .num_i   (acc),
    .den_i   (den_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // result post-processing
  always_comb begin
    p_raw = acc[63:16];
    if (p_raw > 48'sd1073741824)       p_sat = 32'sd1073741824;
    else if (p_raw < -48'sd1073741824) p_sat = -32'sd1073741824;
    else                               p_sat = p_raw[31:0];
    pp    = acc[63:0];
    p24_0 = 64'(p_q[0]) <<< 24;
    p24_1 = 64'(p_q[1]) <<< 24;
    p24_2 = 64'(p_q[2]) <<< 24;
    d_new = (64'(x1_q[ji]) <<< 1) - 64'(x0_q[ji]) + acc[87:24];
    v     = div_quot + 64'(ac_q[ji]);
    h64   = {17'd0, box_q};
    clamp_hit = 1'b1;
    if (v > h64)       v_clamped = h64;
    else if (v < -h64) v_clamped = -h64;
    else begin
      v_clamped = v;
      clamp_hit = 1'b0;
    end
  end

  // sequencer and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= '0;
      job_q   <= '0;
      step_q  <= '0;
      valid_q <= 1'b0;
      clamp_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        e_q[i] <= '0;
        b_q[i] <= '0;
      end
      box_q <= BOX_RESET;
    end else begin
      valid_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_EX:  e_q[0] <= cfg_wdata_i[COEF_W-1:0];
          REG_EY:  e_q[1] <= cfg_wdata_i[COEF_W-1:0];
          REG_EZ:  e_q[2] <= cfg_wdata_i[COEF_W-1:0];
          REG_BX:  b_q[0] <= cfg_wdata_i[COEF_W-1:0];
          REG_BY:  b_q[1] <= cfg_wdata_i[COEF_W-1:0];
          REG_BZ:  b_q[2] <= cfg_wdata_i[COEF_W-1:0];
          REG_BOX: box_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
      unique case (state_q)
        ST_IDLE: if (accept) begin
          pc_q    <= '0;
          job_q   <= '0;
          step_q  <= n_eff;
          clamp_q <= 1'b0;
          if (n_eff == '0) valid_q <= 1'b1;
          else             state_q <= ST_SETUP;
        end
        ST_SETUP, ST_PP: begin
          if (consume) begin
            pc_q <= '0;
            if (job_q == 3'd5) begin
              job_q   <= '0;
              state_q <= (state_q == ST_SETUP) ? ST_PP : ST_CROSS;
            end else begin
              job_q <= job_q + 3'd1;
            end
          end else begin
            pc_q <= pc_q + 4'd1;
          end
        end
        ST_CROSS: begin
          if (consume) begin
            pc_q <= '0;
            if (job_q == 3'd2) begin
              job_q   <= '0;
              state_q <= ST_MAT;
            end else begin
              job_q <= job_q + 3'd1;
            end
          end else begin
            pc_q <= pc_q + 4'd1;
          end
        end
        ST_MAT: begin
          if (consume) begin
            pc_q    <= '0;
            state_q <= ST_DIV;
          end else begin
            pc_q <= pc_q + 4'd1;
          end
        end
        ST_DIV: if (div_done) begin
          if (clamp_hit) clamp_q <= 1'b1;
          if (job_q == 3'd2) begin
            job_q <= '0;
            if (step_q == SUB_W'(1)) begin
              state_q <= ST_DONE;
            end else begin
              step_q  <= step_q - SUB_W'(1);
              state_q <= ST_CROSS;
            end
          end else begin
            job_q   <= job_q + 3'd1;
            state_q <= ST_MAT;
          end
        end
        ST_DONE: begin
          valid_q <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x0_q[0] <= item_i.prev_x;
      x0_q[1] <= item_i.prev_y;
      x0_q[2] <= item_i.prev_z;
      x1_q[0] <= item_i.cur_x;
      x1_q[1] <= item_i.cur_y;
      x1_q[2] <= item_i.cur_z;
      rot_q   <= item_i.rot_coeff;
      accel_q <= item_i.accel_coeff;
      res_q   <= '{new_prev_x: item_i.prev_x, new_prev_y: item_i.prev_y,
                   new_prev_z: item_i.prev_z, new_cur_x: item_i.cur_x,
                   new_cur_y: item_i.cur_y, new_cur_z: item_i.cur_z,
                   was_clamped: 1'b0};
    end
    if (consume) begin
      unique case (state_q)
        ST_SETUP: begin
          if (job_q < 3'd3) p_q[ji] <= p_sat;
          else              ac_q[jm3[1:0]] <= acc[63:32];
        end
        ST_PP: begin
          unique case (job_q)
            3'd0: begin
              m_q[0][0] <= pp + (64'sd1 <<< 48);
              den_q     <= 64'(pp) + (64'd1 << 48);
            end
            3'd1: begin
              m_q[1][1] <= pp + (64'sd1 <<< 48);
              den_q     <= den_q + 64'(pp);
            end
            3'd2: begin
              m_q[2][2] <= pp + (64'sd1 <<< 48);
              den_q     <= den_q + 64'(pp);
            end
            3'd3: begin
              m_q[0][1] <= pp + p24_2;
              m_q[1][0] <= pp - p24_2;
            end
            3'd4: begin
              m_q[0][2] <= pp - p24_1;
              m_q[2][0] <= pp + p24_1;
            end
            default: begin
              m_q[1][2] <= pp + p24_0;
              m_q[2][1] <= pp - p24_0;
            end
          endcase
        end
        ST_CROSS: begin
          d_q[ji] <= d_new;
          if (job_q == 3'd2) begin
            for (int i = 0; i < 3; i++) x0_q[i] <= x1_q[i];
          end
        end
        default: ;
      endcase
    end
    if (state_q == ST_DIV && div_done) begin
      x1_q[ji] <= v_clamped[POS_W-1:0];
    end
    if (state_q == ST_DONE) begin
      res_q <= '{new_prev_x: x0_q[0], new_prev_y: x0_q[1], new_prev_z: x0_q[2],
                 new_cur_x: x1_q[0], new_cur_y: x1_q[1], new_cur_z: x1_q[2],
                 was_clamped: clamp_q};
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

  `CPPU_ASSERT(a_done_strobe, (state_q == ST_DONE) |=> result_valid_o)
  `CPPU_ASSERT(a_start_effect, accept |=> (busy || result_valid_o))
  `CPPU_ASSERT(a_valid_when_idle, result_valid_o |-> !busy)
  `CPPU_ASSERT(a_den_floor, (state_q == ST_DIV) |-> (den_q[63:48] != 16'd0))
  `CPPU_NEVER(a_div_done_stray, div_done && (state_q != ST_DIV))

endmodule

`default_nettype wire
